### sv/hhpc_pkg.sv
`timescale 1ns / 1ps

package hhpc_pkg;

    // configuration register map
    localparam int CFG_ADDR_W = 1;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_CLIP_LINE = 1'd0;
    localparam cfg_addr_t REG_KEEP_SIDE = 1'd1;

    // keep_side codes
    localparam logic SIDE_ABOVE = 1'b0;
    localparam logic SIDE_BELOW = 1'b1;

endpackage

### sv/horizontal_halfplane_polygon_clip.sv
`timescale 1ns / 1ps

// Clips one polygon contour against the horizontal line y = clip_line and
// keeps the part above (keep_side 0) or below (keep_side 1) it.
// Input channel s_*: one vertex per item; tuser = prime loads the vertex as
// the closing (previous) vertex and gives no result. Every other vertex
// closes an edge and gives zero, one or two result items on m_*, the last
// of them marked by m_tlast.
// Configuration: cfg_we/cfg_addr/cfg_wdata, written while the block idles.
// Timing: s_tready is high only while no item is in work. An item without
// a crossing passes from the evaluate state to the emit state and then into
// the output register. An item that needs a crossing runs a bit-serial
// shift-add multiply and a restoring divide, one bit per cycle each, before
// its first result. A prime item or one without results frees the input
// straight from the evaluate state.
// The next item is taken as soon as the last result of the current one
// sits in the output register, even while m_tready is low; a stalled
// receiver holds the second result of an edge inside the block.
// Reset clears the previous vertex to (0,0), clip_line and keep_side to 0
// and empties the output register.
module horizontal_halfplane_polygon_clip #(
    parameter int COORD_WIDTH = 32,
    localparam int TDATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  hhpc_pkg::cfg_addr_t          cfg_addr,
    input  logic [COORD_WIDTH-1:0]       cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [TDATA_W-1:0]           s_tdata,   // vertex_x, vertex_y
    input  logic                         s_tuser,   // prime
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [TDATA_W-1:0]           m_tdata,   // out_x, out_y
    output logic                         m_tlast    // last_in_run
);

    import hhpc_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int WE    = COORD_WIDTH + 1;
    localparam int CNT_W = $clog2(WE + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_DIFF = 3'd2;
    localparam logic [2:0] ST_MAG  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;
    localparam logic [2:0] ST_EMIT = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic signed [W-1:0]    clip_line_reg, clip_line_next;
    logic                   keep_side_reg, keep_side_next;
    logic signed [W-1:0]    prev_x_reg, prev_x_next;
    logic signed [W-1:0]    prev_y_reg, prev_y_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   emit_idx_reg, emit_idx_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic signed [W-1:0]    cur_x_reg, cur_x_next;
    logic signed [W-1:0]    cur_y_reg, cur_y_next;
    logic                   prime_reg, prime_next;
    logic signed [W-1:0]    x0_reg, x0_next;
    logic signed [W-1:0]    y0_reg, y0_next;
    logic signed [W-1:0]    x1_reg, x1_next;
    logic signed [W-1:0]    y1_reg, y1_next;
    logic signed [WE-1:0]   dl_reg, dl_next;
    logic signed [WE-1:0]   dx_reg, dx_next;
    logic signed [WE-1:0]   dy_reg, dy_next;
    logic [WE-1:0]          ma_reg, ma_next;
    logic [WE-1:0]          den_reg, den_next;
    logic [2*WE-1:0]        acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic                   den_zero_reg, den_zero_next;
    logic                   cross_cur_reg, cross_cur_next;
    logic                   pend_two_reg, pend_two_next;
    logic signed [W-1:0]    p0_x_reg, p0_x_next;
    logic signed [W-1:0]    p0_y_reg, p0_y_next;
    logic signed [W-1:0]    p1_x_reg, p1_x_next;
    logic signed [W-1:0]    p1_y_reg, p1_y_next;
    logic signed [W-1:0]    out_x_reg, out_x_next;
    logic signed [W-1:0]    out_y_reg, out_y_next;
    logic                   out_last_reg, out_last_next;

    logic                   cur_on;
    logic                   prev_on;
    logic                   prev_strict;
    logic                   cur_above;
    logic [WE:0]            mul_sum;
    logic [WE:0]            div_trial;
    logic                   div_ge;
    logic [WE:0]            div_diff;
    logic [WE-1:0]          div_rem;
    logic signed [W-1:0]    cross_x;
    logic                   load_ok;
    logic                   step_done;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({out_y_reg, out_x_reg});
    assign m_tlast  = out_last_reg;

    // side tests against the clip line
    always_comb
    begin
        if (keep_side_reg == SIDE_BELOW)
        begin
            cur_on      = (cur_y_reg <= clip_line_reg);
            prev_on     = (prev_y_reg <= clip_line_reg);
            prev_strict = (prev_y_reg < clip_line_reg);
        end
        else
        begin
            cur_on      = (cur_y_reg >= clip_line_reg);
            prev_on     = (prev_y_reg >= clip_line_reg);
            prev_strict = (prev_y_reg > clip_line_reg);
        end
        cur_above = (cur_y_reg > prev_y_reg);
    end

    // one bit of multiply and one bit of divide per cycle
    always_comb
    begin
        mul_sum   = {1'b0, acc_reg[2*WE-1:WE]} + (acc_reg[0] ? {1'b0, ma_reg} : '0);
        div_trial = {acc_reg[2*WE-1:WE], acc_reg[WE-1]};
        div_diff  = div_trial - {1'b0, den_reg};
        div_ge    = (div_trial >= {1'b0, den_reg});
        div_rem   = div_ge ? div_diff[WE-1:0] : div_trial[WE-1:0];
        if (den_zero_reg)
            cross_x = x1_reg;
        else if (neg_reg)
            cross_x = x1_reg - $signed(acc_reg[W-1:0]);
        else
            cross_x = x1_reg + $signed(acc_reg[W-1:0]);
    end

    assign load_ok   = !out_valid_reg || m_tready;
    assign step_done = (cnt_reg == CNT_W'(WE - 1));

    always_comb
    begin
        state_next     = state_reg;
        clip_line_next = clip_line_reg;
        keep_side_next = keep_side_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        out_valid_next = out_valid_reg;
        emit_idx_next  = emit_idx_reg;
        cnt_next       = cnt_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        prime_next     = prime_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        dl_next        = dl_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        ma_next        = ma_reg;
        den_next       = den_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        den_zero_next  = den_zero_reg;
        cross_cur_next = cross_cur_reg;
        pend_two_next  = pend_two_reg;
        p0_x_next      = p0_x_reg;
        p0_y_next      = p0_y_reg;
        p1_x_next      = p1_x_reg;
        p1_y_next      = p1_y_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;

        if (cfg_we)
        begin
            if (cfg_addr == REG_CLIP_LINE)
                clip_line_next = $signed(cfg_wdata);
            else if (cfg_addr == REG_KEEP_SIDE)
                keep_side_next = cfg_wdata[0];
        end

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cur_x_next = $signed(s_tdata[W-1:0]);
                    cur_y_next = $signed(s_tdata[2*W-1:W]);
                    prime_next = s_tuser;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // x1/y1 is the edge end of greater y, the previous one on a tie
                x1_next     = cur_above ? cur_x_reg : prev_x_reg;
                y1_next     = cur_above ? cur_y_reg : prev_y_reg;
                x0_next     = cur_above ? prev_x_reg : cur_x_reg;
                y0_next     = cur_above ? prev_y_reg : cur_y_reg;
                prev_x_next = cur_x_reg;
                prev_y_next = cur_y_reg;
                if (prime_reg)
                    state_next = ST_IDLE;
                else if (cur_on && prev_on)
                begin
                    p0_x_next     = cur_x_reg;
                    p0_y_next     = cur_y_reg;
                    pend_two_next = 1'b0;
                    emit_idx_next = 1'b0;
                    state_next    = ST_EMIT;
                end
                else if (cur_on || prev_strict)
                begin
                    cross_cur_next = cur_on;
                    state_next     = ST_DIFF;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DIFF:
            begin
                dl_next    = WE'(clip_line_reg) - WE'(y1_reg);
                dx_next    = WE'(x0_reg) - WE'(x1_reg);
                dy_next    = WE'(y0_reg) - WE'(y1_reg);
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                ma_next       = dl_reg[WE-1] ? WE'(-dl_reg) : dl_reg;
                den_next      = dy_reg[WE-1] ? WE'(-dy_reg) : dy_reg;
                acc_next      = {{WE{1'b0}}, (dx_reg[WE-1] ? WE'(-dx_reg) : dx_reg)};
                neg_next      = dl_reg[WE-1] ^ dx_reg[WE-1] ^ dy_reg[WE-1];
                den_zero_next = (dy_reg == '0);
                cnt_next      = '0;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                // multiplier bits shift out at the bottom, product builds at the top
                acc_next = {mul_sum, acc_reg[WE-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (step_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // remainder on top, dividend bits leave as quotient bits enter
                acc_next = {div_rem, acc_reg[WE-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (step_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                p0_x_next     = cross_x;
                p0_y_next     = clip_line_reg;
                p1_x_next     = cur_x_reg;
                p1_y_next     = cur_y_reg;
                pend_two_next = cross_cur_reg
                                && !(cross_x == cur_x_reg && clip_line_reg == cur_y_reg);
                emit_idx_next = 1'b0;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    if (!emit_idx_reg)
                    begin
                        out_x_next    = p0_x_reg;
                        out_y_next    = p0_y_reg;
                        out_last_next = !pend_two_reg;
                        if (pend_two_reg)
                            emit_idx_next = 1'b1;
                        else
                            state_next = ST_IDLE;
                    end
                    else
                    begin
                        out_x_next    = p1_x_reg;
                        out_y_next    = p1_y_reg;
                        out_last_next = 1'b1;
                        emit_idx_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clip_line_reg <= '0;
            keep_side_reg <= SIDE_ABOVE;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            out_valid_reg <= 1'b0;
            emit_idx_reg  <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clip_line_reg <= clip_line_next;
            keep_side_reg <= keep_side_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            out_valid_reg <= out_valid_next;
            emit_idx_reg  <= emit_idx_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        prime_reg     <= prime_next;
        x0_reg        <= x0_next;
        y0_reg        <= y0_next;
        x1_reg        <= x1_next;
        y1_reg        <= y1_next;
        dl_reg        <= dl_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        ma_reg        <= ma_next;
        den_reg       <= den_next;
        acc_reg       <= acc_next;
        neg_reg       <= neg_next;
        den_zero_reg  <= den_zero_next;
        cross_cur_reg <= cross_cur_next;
        pend_two_reg  <= pend_two_next;
        p0_x_reg      <= p0_x_next;
        p0_y_reg      <= p0_y_next;
        p1_x_reg      <= p1_x_next;
        p1_y_reg      <= p1_y_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_last_reg  <= out_last_next;
    end

endmodule

### sv/hhpc_checker.sv
`timescale 1ns / 1ps

module hhpc_checker #(
    parameter int COORD_WIDTH = 32,
    localparam int TDATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               s_tuser,   // prime
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,   // out_x, out_y
    input logic               m_tlast    // last_in_run
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result item changed");

    // output register is empty once a reset edge has passed
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
    else $error("result item valid after reset");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in work");

    // a prime item gives no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser && !m_tvalid) |=> !m_tvalid ##1 !m_tvalid)
    else $error("prime item produced a result");

    // the second result of an edge follows without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("gap inside a run of result items");

endmodule

bind horizontal_halfplane_polygon_clip hhpc_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_hhpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
